FILE: rtl/mmpid_pkg.sv
// shared types and constants of the multi-mode pid controller
package mmpid_pkg;

    localparam int unsigned StepW = 4;
    localparam int unsigned OpW   = 33;
    localparam int unsigned ProdW = 2 * OpW;
    localparam int unsigned AccW  = 80;

    localparam logic [2:0] CFG_MODE  = 3'd0;
    localparam logic [2:0] CFG_KP    = 3'd1;
    localparam logic [2:0] CFG_KI    = 3'd2;
    localparam logic [2:0] CFG_KD    = 3'd3;
    localparam logic [2:0] CFG_KG    = 3'd4;
    localparam logic [2:0] CFG_LIMIT = 3'd5;

    localparam logic [1:0] MODE_POS  = 2'd0;
    localparam logic [1:0] MODE_INC  = 2'd1;
    localparam logic [1:0] MODE_DYN  = 2'd2;
    localparam logic [1:0] MODE_TURN = 2'd3;

    localparam logic [14:0] LIMIT_RESET = 15'd2000;

    localparam logic signed [AccW-1:0] SAT_POS = 80'sh4_0000_0000_0000;
    localparam logic signed [AccW-1:0] SAT_NEG = -SAT_POS;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_FIN
    } t_state;

    typedef enum logic [2:0] {
        OPA_KP,
        OPA_KI,
        OPA_KD,
        OPA_KG,
        OPA_GLO,
        OPA_GHI,
        OPA_ERR
    } t_opa;

    typedef enum logic [2:0] {
        OPB_ERR,
        OPB_SUM,
        OPB_DIF,
        OPB_DIFX,
        OPB_GYRO,
        OPB_ESQ
    } t_opb;

    typedef enum logic [1:0] {
        DST_ACC_CLR,
        DST_ACC,
        DST_GAIN,
        DST_ESQ
    } t_dst;

    typedef struct packed {
        logic mul_en;
        t_opa opa;
        t_opb opb;
        t_dst dst;
        logic shift;
        logic chk;
    } t_mul_op;

    typedef struct packed {
        logic    load;
        t_mul_op mul;
        logic    fin;
    } t_dp_cmd;

    typedef struct packed {
        logic [1:0] mode;
    } t_dp_status;

    localparam t_mul_op MUL_IDLE = '{
        mul_en: 1'b0, opa: OPA_KP, opb: OPB_ERR, dst: DST_ACC, shift: 1'b0, chk: 1'b0
    };

endpackage

FILE: rtl/mmpid_ctrl.sv
// controller: sequences the multiply steps of each control law
module mmpid_ctrl import mmpid_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic       i_ready,
    input  t_dp_status i_status,
    output logic       o_ready,
    output logic       o_valid,
    output t_dp_cmd    o_cmd
);

    t_state             r_state, n_state;
    logic [StepW-1:0]   r_step, n_step;
    logic               r_out_valid, n_out_valid;

    function automatic t_mul_op op(input t_opa a, input t_opb b, input t_dst d,
                                   input logic sh, input logic ck);
        t_mul_op m;
        m.mul_en = 1'b1;
        m.opa    = a;
        m.opb    = b;
        m.dst    = d;
        m.shift  = sh;
        m.chk    = ck;
        return m;
    endfunction

    function automatic logic [StepW-1:0] last_step(input logic [1:0] mode);
        logic [StepW-1:0] n;
        case (mode)
            MODE_POS:  n = StepW'(3);
            MODE_INC:  n = StepW'(2);
            MODE_DYN:  n = StepW'(5);
            default:   n = StepW'(8);
        endcase
        return n;
    endfunction

    function automatic t_mul_op step_op(input logic [1:0] mode, input logic [StepW-1:0] step);
        t_mul_op m;
        m = MUL_IDLE;
        case (mode)
            MODE_POS: begin
                case (step)
                    StepW'(0): m = op(OPA_KP, OPB_ERR, DST_ACC_CLR, 1'b0, 1'b0);
                    StepW'(1): m = op(OPA_KI, OPB_SUM, DST_ACC, 1'b0, 1'b0);
                    StepW'(2): m = op(OPA_KD, OPB_DIF, DST_ACC, 1'b0, 1'b0);
                    default:   m = MUL_IDLE;
                endcase
            end
            MODE_INC: begin
                case (step)
                    StepW'(0): m = op(OPA_KP, OPB_DIFX, DST_ACC_CLR, 1'b0, 1'b0);
                    StepW'(1): m = op(OPA_KI, OPB_ERR, DST_ACC, 1'b0, 1'b0);
                    default:   m = MUL_IDLE;
                endcase
            end
            MODE_DYN: begin
                case (step)
                    StepW'(0): m = op(OPA_KI, OPB_ERR, DST_GAIN, 1'b0, 1'b0);
                    StepW'(2): m = op(OPA_GLO, OPB_ERR, DST_ACC_CLR, 1'b0, 1'b0);
                    StepW'(3): m = op(OPA_GHI, OPB_ERR, DST_ACC, 1'b1, 1'b0);
                    StepW'(4): m = op(OPA_KD, OPB_DIFX, DST_ACC, 1'b0, 1'b0);
                    default:   m = MUL_IDLE;
                endcase
            end
            default: begin
                case (step)
                    StepW'(0): m = op(OPA_ERR, OPB_ERR, DST_ESQ, 1'b0, 1'b0);
                    StepW'(2): m = op(OPA_KI, OPB_ESQ, DST_GAIN, 1'b0, 1'b0);
                    StepW'(4): m = op(OPA_GLO, OPB_ERR, DST_ACC_CLR, 1'b0, 1'b0);
                    StepW'(5): m = op(OPA_GHI, OPB_ERR, DST_ACC, 1'b1, 1'b0);
                    StepW'(6): m = op(OPA_KD, OPB_DIF, DST_ACC, 1'b0, 1'b1);
                    StepW'(7): m = op(OPA_KG, OPB_GYRO, DST_ACC, 1'b0, 1'b0);
                    default:   m = MUL_IDLE;
                endcase
            end
        endcase
        return m;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_out_valid = r_out_valid && !i_ready;
        o_cmd.load  = 1'b0;
        o_cmd.mul   = MUL_IDLE;
        o_cmd.fin   = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_step     = '0;
                    n_state    = ST_MUL;
                end
            end
            ST_MUL: begin
                o_cmd.mul = step_op(i_status.mode, r_step);
                if (r_step == last_step(i_status.mode)) begin
                    n_state = ST_FIN;
                end else begin
                    n_step = r_step + StepW'(1);
                end
            end
            ST_FIN: begin
                if (!r_out_valid || i_ready) begin
                    o_cmd.fin   = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_ready = (r_state == ST_IDLE);
    assign o_valid = r_out_valid;

endmodule

FILE: rtl/mmpid_dp.sv
// datapath: config registers, error state, shared multiplier, accumulator, output
module mmpid_dp import mmpid_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data,
    input  logic signed [15:0] i_setpoint,
    input  logic signed [15:0] i_measured,
    input  logic signed [15:0] i_gyro_rate,
    input  t_dp_cmd            i_cmd,
    output t_dp_status         o_status,
    output logic signed [15:0] o_drive
);

    logic [1:0]          r_mode;
    logic signed [31:0]  r_kp, r_ki, r_kd, r_kg;
    logic [14:0]         r_lim;

    logic signed [15:0]  r_prev, r_isum;
    logic signed [15:0]  r_err, r_dif, r_sum, r_gyro;
    logic signed [16:0]  r_difx;
    logic [30:0]         r_esq;
    logic signed [63:0]  r_gain;
    logic signed [AccW-1:0] r_acc;
    logic                r_sat, r_sat_neg;

    logic                r_pv;
    t_dst                r_pdst;
    logic                r_pshift, r_pchk;
    logic signed [ProdW-1:0] r_prod;

    logic signed [15:0]  r_drive;

    logic signed [15:0]  w_err;
    logic signed [16:0]  w_difx, w_isum, w_lim, w_nlim;
    logic signed [15:0]  w_sum;
    logic signed [OpW-1:0]   w_opa, w_opb;
    logic signed [ProdW-1:0] w_prod;
    logic signed [AccW-1:0]  w_ext, w_term;
    logic                w_rnd;
    logic signed [63:0]  w_q;
    logic signed [15:0]  w_drive;

    // error, differences and clamped integral from the incoming sample
    always_comb begin
        w_err  = (r_mode == MODE_TURN) ? i_setpoint : 16'(i_setpoint - i_measured);
        w_difx = {w_err[15], w_err} - {r_prev[15], r_prev};
        w_isum = {r_isum[15], r_isum} + {w_err[15], w_err};
        w_lim  = $signed({2'b00, r_lim});
        w_nlim = -w_lim;
        if (w_isum > w_lim) begin
            w_sum = w_lim[15:0];
        end else if (w_isum < w_nlim) begin
            w_sum = w_nlim[15:0];
        end else begin
            w_sum = w_isum[15:0];
        end
    end

    always_comb begin
        case (i_cmd.mul.opa)
            OPA_KP:  w_opa = {r_kp[31], r_kp};
            OPA_KI:  w_opa = {r_ki[31], r_ki};
            OPA_KD:  w_opa = {r_kd[31], r_kd};
            OPA_KG:  w_opa = {r_kg[31], r_kg};
            OPA_GLO: w_opa = $signed({1'b0, r_gain[31:0]});
            OPA_GHI: w_opa = {r_gain[63], r_gain[63:32]};
            OPA_ERR: w_opa = OpW'(r_err);
            default: w_opa = '0;
        endcase
        case (i_cmd.mul.opb)
            OPB_ERR:  w_opb = OpW'(r_err);
            OPB_SUM:  w_opb = OpW'(r_sum);
            OPB_DIF:  w_opb = OpW'(r_dif);
            OPB_DIFX: w_opb = OpW'(r_difx);
            OPB_GYRO: w_opb = OpW'(r_gyro);
            OPB_ESQ:  w_opb = $signed({2'b00, r_esq});
            default:  w_opb = '0;
        endcase
    end

    assign w_prod = w_opa * w_opb;

    always_comb begin
        w_ext  = AccW'(r_prod);
        w_term = r_pshift ? {w_ext[AccW-33:0], 32'd0} : w_ext;
    end

    // truncate toward zero, then saturate to int16
    always_comb begin
        w_rnd = r_acc[AccW-1] && (|r_acc[15:0]);
        w_q   = $signed(r_acc[AccW-1:16]) + $signed({63'd0, w_rnd});
        if (r_sat) begin
            w_drive = r_sat_neg ? -16'sd32768 : 16'sd32767;
        end else if (w_q > 64'sd32767) begin
            w_drive = 16'sd32767;
        end else if (w_q < -64'sd32768) begin
            w_drive = -16'sd32768;
        end else begin
            w_drive = w_q[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_POS;
            r_kp   <= '0;
            r_ki   <= '0;
            r_kd   <= '0;
            r_kg   <= '0;
            r_lim  <= LIMIT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_MODE:  r_mode <= i_cfg_data[1:0];
                CFG_KP:    r_kp   <= i_cfg_data;
                CFG_KI:    r_ki   <= i_cfg_data;
                CFG_KD:    r_kd   <= i_cfg_data;
                CFG_KG:    r_kg   <= i_cfg_data;
                CFG_LIMIT: r_lim  <= i_cfg_data[14:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev <= '0;
            r_isum <= '0;
            r_pv   <= 1'b0;
        end else begin
            r_pv <= i_cmd.mul.mul_en;
            if (i_cmd.load) begin
                r_prev <= w_err;
                if (r_mode == MODE_POS) begin
                    r_isum <= w_sum;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_err   <= w_err;
            r_difx  <= w_difx;
            r_dif   <= w_difx[15:0];
            r_sum   <= w_sum;
            r_gyro  <= i_gyro_rate;
            r_sat   <= 1'b0;
        end
        if (i_cmd.mul.mul_en) begin
            r_prod   <= w_prod;
            r_pdst   <= i_cmd.mul.dst;
            r_pshift <= i_cmd.mul.shift;
            r_pchk   <= i_cmd.mul.chk;
        end
        if (r_pv) begin
            if (r_pchk) begin
                r_sat     <= (r_acc >= SAT_POS) || (r_acc <= SAT_NEG);
                r_sat_neg <= r_acc[AccW-1];
            end
            case (r_pdst)
                DST_ACC_CLR: r_acc  <= w_term;
                DST_ACC:     r_acc  <= r_acc + w_term;
                DST_GAIN:    r_gain <= r_prod[63:0] + 64'(r_kp);
                DST_ESQ:     r_esq  <= r_prod[30:0];
                default: ;
            endcase
        end
        if (i_cmd.fin) begin
            r_drive <= w_drive;
        end
    end

    assign o_status.mode = r_mode;
    assign o_drive       = r_drive;

endmodule

FILE: rtl/multi_mode_pid_controller_core.sv
// top level of the multi-mode pid controller
//
// input channel: i_valid / o_ready carry one sample (setpoint, measured,
// gyro rate); a transfer happens when both are high. output channel:
// o_valid / i_ready carry one drive value per sample.
// configuration: i_cfg_we writes i_cfg_data to register i_cfg_index
// (mode, kp, ki, kd, kg, integral limit); write only when idle.
// one shared 33x33 multiplier runs the law as a short sequence of steps,
// each product registered before it is accumulated; dependent steps
// wait until the earlier product has reached its register. the step
// sequence sets the cost per sample and differs by mode; the next
// sample is taken only once the last drive is in the output register.
// the drive sits in an output register; the next sample is accepted while
// it waits, and the block holds its finished result until i_ready frees it.
// reset clears the previous error, the integral sum, all gains and the
// mode, and sets the integral limit to 2000; no output is pending after it.
module multi_mode_pid_controller_core import mmpid_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic signed [15:0] i_setpoint,
    input  logic signed [15:0] i_measured,
    input  logic signed [15:0] i_gyro_rate,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [15:0] o_drive
);

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    mmpid_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_ready  (i_ready),
        .i_status (w_status),
        .o_ready  (o_ready),
        .o_valid  (o_valid),
        .o_cmd    (w_cmd)
    );

    mmpid_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_setpoint  (i_setpoint),
        .i_measured  (i_measured),
        .i_gyro_rate (i_gyro_rate),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .o_drive     (o_drive)
    );

endmodule

FILE: rtl/mmpid_checker.sv
// port-level assertions of the multi-mode pid controller and their bind
module mmpid_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_cfg_we,
    input logic [2:0]         i_cfg_index,
    input logic [31:0]        i_cfg_data,
    input logic               i_valid,
    input logic               o_ready,
    input logic signed [15:0] i_setpoint,
    input logic signed [15:0] i_measured,
    input logic signed [15:0] i_gyro_rate,
    input logic               o_valid,
    input logic               i_ready,
    input logic signed [15:0] o_drive
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_drive))
        else $error("stalled drive changed or dropped");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("new sample taken while one is in flight");

    a_result_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> !$past(o_ready))
        else $error("drive appeared without a sample in flight");

endmodule

bind multi_mode_pid_controller_core mmpid_checker u_mmpid_checker (.*);

FILE: tb/multi_mode_pid_controller_core_tb.sv
// self-checking testbench of the multi-mode pid controller core
module multi_mode_pid_controller_core_tb import mmpid_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] CFG_SPARE_LO = 3'd6;
    localparam logic [2:0] CFG_SPARE_HI = 3'd7;
    localparam logic signed [31:0] GAIN_ONE = 32'sh0001_0000;
    localparam logic signed [31:0] GAIN_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] GAIN_MIN = 32'sh8000_0000;
    localparam longint DYN_SAT = 64'sd1 <<< 50;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic [2:0]         i_cfg_index = CFG_MODE;
    logic [31:0]        i_cfg_data = '0;
    logic               i_valid = 1'b0;
    logic               o_ready;
    logic signed [15:0] i_setpoint = '0;
    logic signed [15:0] i_measured = '0;
    logic signed [15:0] i_gyro_rate = '0;
    logic               o_valid;
    logic               i_ready = 1'b0;
    logic signed [15:0] o_drive;

    // predictor copy of the registers and the loop state
    logic [1:0]         mode_reg = MODE_POS;
    logic signed [31:0] kp_reg = '0;
    logic signed [31:0] ki_reg = '0;
    logic signed [31:0] kd_reg = '0;
    logic signed [31:0] kg_reg = '0;
    logic [14:0]        limit_reg = LIMIT_RESET;
    logic signed [15:0] prev_error = '0;
    logic signed [15:0] integral_sum = '0;

    logic signed [15:0] expected_drives[$];
    int unsigned        mismatch_count = 0;
    int unsigned        drive_count = 0;
    bit                 send_gaps_on = 1'b1;
    bit                 ready_gaps_on = 1'b1;

    multi_mode_pid_controller_core DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_setpoint  (i_setpoint),
        .i_measured  (i_measured),
        .i_gyro_rate (i_gyro_rate),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_drive     (o_drive)
    );

    always #4 i_clk = ~i_clk;

    function automatic int unsigned draw_wait(input bit gaps_on);
        return gaps_on ? $urandom_range(0, 7) : 0;
    endfunction

    function automatic logic signed [15:0] predict_drive(input logic signed [15:0] sp,
                                                         input logic signed [15:0] ms,
                                                         input logic signed [15:0] gy);
        logic signed [15:0] err;
        logic signed [15:0] dif16;
        longint e, p, s, g, v, q, mag_g, mag_e;
        p = prev_error;
        if (mode_reg == MODE_TURN) begin
            err = sp;
            e = err;
            dif16 = err - prev_error;
            g = longint'(ki_reg) * (e * e) + longint'(kp_reg);
            v = longint'(kd_reg) * longint'(dif16) + longint'(kg_reg) * longint'(gy);
            mag_g = (g < 0) ? -g : g;
            mag_e = (e < 0) ? -e : e;
            if (mag_e != 0 && mag_g > (DYN_SAT - 1) / mag_e) begin
                q = ((g < 0) != (e < 0)) ? -32768 : 32767;
            end else begin
                q = (g * e + v) / 65536;
            end
        end else begin
            err = sp - ms;
            e = err;
            dif16 = err - prev_error;
            case (mode_reg)
                MODE_POS: begin
                    s = longint'(integral_sum) + e;
                    if (s > longint'(limit_reg)) s = longint'(limit_reg);
                    if (s < -longint'(limit_reg)) s = -longint'(limit_reg);
                    integral_sum = 16'(s);
                    v = longint'(kp_reg) * e + longint'(ki_reg) * s
                      + longint'(kd_reg) * longint'(dif16);
                end
                MODE_INC: begin
                    v = longint'(kp_reg) * (e - p) + longint'(ki_reg) * e;
                end
                default: begin
                    g = longint'(ki_reg) * e + longint'(kp_reg);
                    v = g * e + longint'(kd_reg) * (e - p);
                end
            endcase
            q = v / 65536;
        end
        if (q > 32767) q = 32767;
        if (q < -32768) q = -32768;
        prev_error = err;
        return 16'(q);
    endfunction

    function automatic logic signed [31:0] pick_gain(input int unsigned span);
        int r;
        if ($urandom_range(0, 9) == 0) return $urandom;
        r = int'($urandom_range(0, (2 << span) - 1)) - (1 << span);
        return 32'(r);
    endfunction

    function automatic logic signed [15:0] pick_value();
        case ($urandom_range(0, 7))
            0: return 16'($urandom);
            1: begin
                case ($urandom_range(0, 3))
                    0: return 16'sh7FFF;
                    1: return 16'sh8000;
                    2: return 16'sh0000;
                    default: return 16'shFFFF;
                endcase
            end
            default: return 16'(int'($urandom_range(0, 1200)) - 600);
        endcase
    endfunction

    task automatic report_mismatch(input string what);
        $display("[%0t] %s", $time, what);
        mismatch_count++;
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (expected_drives.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
        wait_drained();
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            CFG_MODE:  mode_reg = data[1:0];
            CFG_KP:    kp_reg = data;
            CFG_KI:    ki_reg = data;
            CFG_KD:    kd_reg = data;
            CFG_KG:    kg_reg = data;
            CFG_LIMIT: limit_reg = data[14:0];
            default: ;
        endcase
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send_sample(input logic signed [15:0] sp,
                               input logic signed [15:0] ms,
                               input logic signed [15:0] gy);
        int unsigned gap;
        gap = draw_wait(send_gaps_on);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_setpoint <= sp;
        i_measured <= ms;
        i_gyro_rate <= gy;
        do @(posedge i_clk); while (o_ready !== 1'b1);
        expected_drives.push_back(predict_drive(sp, ms, gy));
    endtask

    task automatic test_reset_defaults();
        send_sample(16'sd1234, -16'sd77, 16'sd5);
    endtask

    task automatic test_positional();
        write_reg(CFG_MODE, 32'(MODE_POS));
        write_reg(CFG_KP, GAIN_ONE);
        write_reg(CFG_KI, GAIN_ONE);
        write_reg(CFG_KD, GAIN_ONE);
        send_sample(16'sd1500, 16'sd0, 16'sd0);
        send_sample(16'sd1500, 16'sd0, 16'sd0);
        send_sample(16'sh7FFF, 16'sh8000, 16'sd0);
        send_sample(16'sh8000, 16'sh7FFF, 16'sd0);
        write_reg(CFG_LIMIT, 32'd0);
        send_sample(16'sd300, 16'sd100, 16'sd0);
        write_reg(CFG_LIMIT, 32'h0000_7FFF);
        send_sample(16'sh7FFF, 16'sd0, 16'sd0);
        send_sample(16'sh7FFF, 16'sd0, 16'sd0);
        write_reg(CFG_KP, GAIN_MAX);
        write_reg(CFG_KI, 32'd0);
        write_reg(CFG_KD, 32'd0);
        send_sample(16'sh7FFF, 16'sd0, 16'sd0);
        write_reg(CFG_KP, GAIN_MIN);
        send_sample(16'sh7FFF, 16'sd0, 16'sd0);
        send_sample(16'sh8000, 16'sd0, 16'sd0);
    endtask

    task automatic test_incremental();
        write_reg(CFG_MODE, 32'(MODE_INC));
        write_reg(CFG_KP, GAIN_ONE);
        write_reg(CFG_KI, GAIN_ONE >>> 2);
        send_sample(16'sh7FFF, 16'sd0, 16'sd0);
        send_sample(16'sh8000, 16'sd0, 16'sd0);
        send_sample(16'sd0, 16'sd0, 16'sd0);
    endtask

    task automatic test_dynamic_p();
        write_reg(CFG_MODE, 32'(MODE_DYN));
        write_reg(CFG_KI, 32'sd64);
        write_reg(CFG_KD, GAIN_ONE >>> 1);
        send_sample(16'sd400, 16'sd0, 16'sd0);
        send_sample(-16'sd400, 16'sd0, 16'sd0);
        send_sample(16'sh7FFF, 16'shFFFF, 16'sd0);
    endtask

    task automatic test_turn();
        write_reg(CFG_MODE, 32'(MODE_TURN));
        write_reg(CFG_KP, GAIN_ONE);
        write_reg(CFG_KI, GAIN_MAX);
        write_reg(CFG_KD, 32'd0);
        write_reg(CFG_KG, GAIN_ONE);
        // huge dynamic gain saturates in both signs
        send_sample(16'sh7FFF, 16'sd123, 16'sh8000);
        send_sample(16'sh8000, 16'sd0, 16'sh7FFF);
        send_sample(16'sd0, 16'sd5, 16'sh7FFF);
        write_reg(CFG_KI, 32'sd1);
        write_reg(CFG_KD, GAIN_ONE);
        send_sample(16'sd100, 16'sd0, -16'sd100);
    endtask

    task automatic test_register_decode();
        write_reg(CFG_SPARE_LO, 32'hDEAD_BEEF);
        write_reg(CFG_SPARE_HI, 32'hFFFF_FFFF);
        write_reg(CFG_MODE, 32'hFFFF_FFFD);
        write_reg(CFG_LIMIT, 32'hFFFF_8064);
        write_reg(CFG_KP, GAIN_ONE);
        write_reg(CFG_KI, GAIN_ONE);
        write_reg(CFG_MODE, 32'hABCD_0000);
        send_sample(16'sd150, 16'sd0, 16'sd0);
        send_sample(16'sd150, 16'sd0, 16'sd0);
    endtask

    task automatic test_random_phases();
        logic [31:0] word;
        logic [1:0]  law;
        for (int phase = 0; phase < 15; phase++) begin
            law = 2'($urandom_range(0, 3));
            word = $urandom;
            word[1:0] = law;
            write_reg(CFG_MODE, word);
            write_reg(CFG_KP, pick_gain(18));
            write_reg(CFG_KI, pick_gain(law == MODE_TURN ? 2 : (law == MODE_DYN ? 8 : 15)));
            write_reg(CFG_KD, pick_gain(16));
            write_reg(CFG_KG, pick_gain(16));
            word = $urandom;
            case ($urandom_range(0, 3))
                0: word[14:0] = '0;
                1: word[14:0] = '1;
                default: word[14:0] = 15'($urandom_range(0, 3000));
            endcase
            write_reg(CFG_LIMIT, word);
            if ($urandom_range(0, 3) == 0) begin
                write_reg($urandom_range(0, 1) ? CFG_SPARE_LO : CFG_SPARE_HI, $urandom);
            end
            send_gaps_on = ($urandom_range(0, 3) != 0);
            ready_gaps_on = ($urandom_range(0, 3) != 0);
            repeat (50) send_sample(pick_value(), pick_value(), pick_value());
        end
        send_gaps_on = 1'b1;
        ready_gaps_on = 1'b1;
    endtask

    initial begin
        int unsigned n;
        forever begin
            n = draw_wait(ready_gaps_on);
            if (n > 0) begin
                i_ready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (o_valid !== 1'b1);
        end
    end

    always @(posedge i_clk) begin
        logic signed [15:0] want_drive;
        if (i_rst_n && o_valid === 1'b1 && i_ready) begin
            drive_count++;
            if (expected_drives.size() == 0) begin
                report_mismatch($sformatf("unexpected drive transfer %0d, value %0d",
                                          drive_count, o_drive));
            end else begin
                want_drive = expected_drives.pop_front();
                if (o_drive !== want_drive) begin
                    report_mismatch($sformatf("drive transfer %0d: got %0d, want %0d",
                                              drive_count, o_drive, want_drive));
                end
            end
        end
    end

    initial begin
        #5_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_defaults();
        test_positional();
        test_incremental();
        test_dynamic_p();
        test_turn();
        test_register_decode();
        test_random_phases();
        wait_drained();
        repeat (16) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

FILE: filelist.f
rtl/mmpid_pkg.sv
rtl/mmpid_ctrl.sv
rtl/mmpid_dp.sv
rtl/multi_mode_pid_controller_core.sv
rtl/mmpid_checker.sv
tb/multi_mode_pid_controller_core_tb.sv
